[hdl/nfp_pkg.sv]
// ----------------------------------------------------------------------------
// Newton fractal pixel package
// Shared widths, fixed-point constants, codes and types of the pixel engine.
// ----------------------------------------------------------------------------
package nfp_pkg;

	localparam int FRAC_BITS      = 28;
	localparam int COORD_BITS     = 12;
	localparam int PALETTE_LENGTH = 256;

	localparam int VW = FRAC_BITS + 12;
	localparam int MW = FRAC_BITS + 5;
	localparam int PW = 2 * MW;
	localparam int ZW = (COORD_BITS + 34 > VW) ? COORD_BITS + 34 : VW;
	localparam int QW = FRAC_BITS + 5;
	localparam int MV_W = 17;

	localparam logic [2:0] CFG_LEFT_REAL = 3'd0;
	localparam logic [2:0] CFG_TOP_IMAG  = 3'd1;
	localparam logic [2:0] CFG_STEP_REAL = 3'd2;
	localparam logic [2:0] CFG_STEP_IMAG = 3'd3;
	localparam logic [2:0] CFG_LIMIT     = 3'd4;

	function automatic logic [63:0] isqrt_c(input logic [127:0] x);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ((128'(c) * 128'(c)) <= x) begin
				r = c;
			end
		end
		return r;
	endfunction

	localparam logic [127:0] HALF_ROOT_W = 128'(isqrt_c(128'd3 << (2 * FRAC_BITS - 2)));
	localparam logic [127:0] THR_W =
		((128'd1 << (2 * FRAC_BITS)) / 128'd100000000) + 128'd1;

	localparam logic signed [ZW-1:0] FX_ONE_Z   = ZW'(128'd1 << FRAC_BITS);
	localparam logic signed [ZW-1:0] FX_HALF_Z  = ZW'(128'd1 << (FRAC_BITS - 1));
	localparam logic signed [ZW-1:0] HALF_ROOT  = ZW'(HALF_ROOT_W);
	localparam logic signed [ZW-1:0] ESC_LIMIT  = ZW'(128'd1 << (FRAC_BITS + 1));
	localparam logic signed [VW-1:0] FX_ONE_V   = VW'(128'd1 << FRAC_BITS);
	localparam logic signed [VW-1:0] N2_LIMIT   = VW'(128'd1 << (FRAC_BITS + 2));
	localparam logic [QW-1:0]        QSAT       = QW'(128'd1 << (FRAC_BITS + 3));
	localparam logic [PW:0]          THR        = THR_W[PW:0];

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_MUL, S_NORM, S_DEN, S_DIVR, S_DIVI, S_ROOT, S_OUT
	} nfp_state_t;

	typedef enum logic [3:0] {
		M_RR, M_II, M_RI, M_ZRR, M_ZII, M_ZRI, M_ZIR, M_DRR, M_DII,
		M_NRD, M_NID, M_NIR, M_NRI, M_EX, M_EY
	} mop_t;

	typedef struct packed {
		logic signed [ZW-1:0] zr;
		logic signed [ZW-1:0] zi;
	} zpoint_t;

	typedef struct packed {
		logic        converged;
		logic [1:0]  root_index;
		logic [15:0] step_count;
		logic [7:0]  palette_index;
	} result_t;

endpackage

[hdl/newton_fractal_pixel.sv]
// ----------------------------------------------------------------------------
// Newton fractal pixel
// Maps a pixel onto the complex plane and runs Newton steps for z^3 - 1.
// ----------------------------------------------------------------------------
// Each accepted pixel word returns one result word in order. The front end
// maps the pixel into a registered start point and parks start points in a
// two-entry queue, so pixel words keep flowing while the engine works until
// the queue is full. The engine handles one pixel at a time on one shared
// multiplier and one shared divider, which finishes early when its quotient
// saturates. A Newton step ends sooner when the first root test hits than
// when all three fail, and a result word may wait on the output until taken.
// Write registers through the configuration port only while idle; the block
// itself does not enforce this.
module newton_fractal_pixel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [2:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [nfp_pkg::COORD_BITS-1:0] column,
	input  logic [nfp_pkg::COORD_BITS-1:0] row,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           converged,
	output logic [1:0]                     root_index,
	output logic [15:0]                    step_count,
	output logic [7:0]                     palette_index
);

	logic signed [31:0] left_real_q;
	logic signed [31:0] top_imag_q;
	logic [30:0]        step_real_q;
	logic [30:0]        step_imag_q;
	logic [15:0]        limit_q;

	logic               push, full, pop, not_empty;
	nfp_pkg::zpoint_t   push_data, pop_data;
	nfp_pkg::result_t   result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_real_q <= -32'sd536870912;
			top_imag_q  <= 32'sd536870912;
			step_real_q <= 31'd1048576;
			step_imag_q <= 31'd1048576;
			limit_q     <= 16'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nfp_pkg::CFG_LEFT_REAL: left_real_q <= cfg_data;
				nfp_pkg::CFG_TOP_IMAG:  top_imag_q  <= cfg_data;
				nfp_pkg::CFG_STEP_REAL: step_real_q <= cfg_data[30:0];
				nfp_pkg::CFG_STEP_IMAG: step_imag_q <= cfg_data[30:0];
				nfp_pkg::CFG_LIMIT:     limit_q     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	nfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.column    (column),
		.row       (row),
		.left_real (left_real_q),
		.top_imag  (top_imag_q),
		.step_real (step_real_q),
		.step_imag (step_imag_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	nfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	nfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (not_empty),
		.pt        (pop_data),
		.pop       (pop),
		.limit     (limit_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign converged     = result.converged;
	assign root_index    = result.root_index;
	assign step_count    = result.step_count;
	assign palette_index = result.palette_index;

endmodule

[hdl/nfp_queue.sv]
// ----------------------------------------------------------------------------
// Start point queue
// Two-entry queue of start points between the front and the iteration engine.
// ----------------------------------------------------------------------------
module nfp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nfp_pkg::zpoint_t push_data,
	output logic             full,
	input  logic             pop,
	output nfp_pkg::zpoint_t pop_data,
	output logic             not_empty
);

	nfp_pkg::zpoint_t mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[hdl/nfp_front.sv]
// ----------------------------------------------------------------------------
// Pixel front end
// Takes pixel words and maps column and row onto a complex start point.
// ----------------------------------------------------------------------------
module nfp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [nfp_pkg::COORD_BITS-1:0]    column,
	input  logic [nfp_pkg::COORD_BITS-1:0]    row,
	input  logic signed [31:0]                left_real,
	input  logic signed [31:0]                top_imag,
	input  logic [30:0]                       step_real,
	input  logic [30:0]                       step_imag,
	output logic                              push,
	output nfp_pkg::zpoint_t                  push_data,
	input  logic                              full
);

	localparam int ZW = nfp_pkg::ZW;

	logic                                   valid_s1;
	nfp_pkg::zpoint_t                       pt_s1;
	logic [nfp_pkg::COORD_BITS+30:0]        off_r;
	logic [nfp_pkg::COORD_BITS+30:0]        off_i;

	assign off_r     = column * step_real;
	assign off_i     = row * step_imag;
	assign push      = valid_s1 && !full;
	assign in_ready  = !valid_s1 || !full;
	assign push_data = pt_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pt_s1.zr <= ZW'(left_real) + $signed(ZW'(off_r));
			pt_s1.zi <= ZW'(top_imag) - $signed(ZW'(off_i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

[hdl/nfp_mul.sv]
// ----------------------------------------------------------------------------
// Shared multiplier
// Magnitude product of two signed operands in two half-width passes.
// ----------------------------------------------------------------------------
module nfp_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [nfp_pkg::VW-1:0] a,
	input  logic signed [nfp_pkg::VW-1:0] b,
	output logic                          done,
	output logic [nfp_pkg::PW-1:0]        prod,
	output logic                          neg
);

	localparam int VW = nfp_pkg::VW;
	localparam int MW = nfp_pkg::MW;
	localparam int PW = nfp_pkg::PW;
	localparam int HB = (MW + 1) / 2;

	logic [VW-1:0]    am;
	logic [VW-1:0]    bm;
	logic [MW-1:0]    a_q;
	logic [MW-1:0]    b_q;
	logic [HB-1:0]    bsel;
	logic [MW+HB-1:0] pp;
	logic             busy_q;
	logic             ph_q;

	assign am   = a[VW-1] ? VW'(-a) : VW'(a);
	assign bm   = b[VW-1] ? VW'(-b) : VW'(b);
	assign bsel = ph_q ? HB'(b_q[MW-1:HB]) : b_q[HB-1:0];
	assign pp   = a_q * bsel;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= am[MW-1:0];
			b_q <= bm[MW-1:0];
			neg <= a[VW-1] ^ b[VW-1];
		end else if (busy_q) begin
			if (!ph_q) begin
				prod <= PW'(pp);
			end else begin
				prod <= prod + (PW'(pp) << HB);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
			done   <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			ph_q   <= 1'b0;
			done   <= 1'b0;
		end else if (busy_q) begin
			ph_q   <= 1'b1;
			busy_q <= !ph_q;
			done   <= ph_q;
		end else begin
			done <= 1'b0;
		end
	end

endmodule

[hdl/nfp_div.sv]
// ----------------------------------------------------------------------------
// Shared divider
// Restoring fixed-point division, one quotient bit per cycle, saturated to 8.
// ----------------------------------------------------------------------------
module nfp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [nfp_pkg::VW-1:0] p,
	input  logic signed [nfp_pkg::VW-1:0] d,
	output logic                          done,
	output logic signed [nfp_pkg::VW-1:0] quot
);

	localparam int VW = nfp_pkg::VW;
	localparam int QW = nfp_pkg::QW;
	localparam int FB = nfp_pkg::FRAC_BITS;
	localparam int CW = $clog2(QW + 1);

	logic [VW-1:0] pm;
	logic          big;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] d_q;
	logic [QW-1:0] sh_q;
	logic [QW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          sat_q;
	logic          neg_q;
	logic [VW:0]   t;
	logic [VW:0]   t_sub;
	logic          ge;
	logic [QW-1:0] m;

	assign pm    = p[VW-1] ? VW'(-p) : VW'(p);
	assign big   = {5'd0, pm} >= {d, 5'd0};
	assign t     = {rem_q, sh_q[QW-1]};
	assign t_sub = t - {1'b0, d_q};
	assign ge    = t >= {1'b0, d_q};
	assign m     = (sat_q || q_q > nfp_pkg::QSAT) ? nfp_pkg::QSAT : q_q;
	assign quot  = neg_q ? -$signed(VW'(m)) : $signed(VW'(m));

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= d;
			neg_q <= p[VW-1];
			sat_q <= big;
			rem_q <= pm >> 5;
			sh_q  <= {pm[4:0], {FB{1'b0}}};
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? t_sub[VW-1:0] : t[VW-1:0];
			sh_q  <= sh_q << 1;
			q_q   <= {q_q[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else if (start) begin
			busy_q <= !big;
			done   <= big;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
			done   <= (cnt_q == CW'(1));
		end else begin
			done <= 1'b0;
		end
	end

endmodule

[hdl/nfp_back.sv]
// ----------------------------------------------------------------------------
// Newton iteration engine
// Runs the Newton steps of one start point on the shared units and holds the result.
// ----------------------------------------------------------------------------
module nfp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pt_valid,
	input  nfp_pkg::zpoint_t      pt,
	output logic                  pop,
	input  logic [15:0]           limit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output nfp_pkg::result_t      result
);

	localparam int VW = nfp_pkg::VW;
	localparam int ZW = nfp_pkg::ZW;
	localparam int PW = nfp_pkg::PW;
	localparam int FB = nfp_pkg::FRAC_BITS;
	localparam int MV_W = nfp_pkg::MV_W;

	nfp_pkg::nfp_state_t state_q, state_d;
	nfp_pkg::mop_t       mop_q, mop_d;
	logic [1:0]          root_q, root_d;

	logic signed [ZW-1:0] zr_q, zi_q;
	logic signed [VW-1:0] prr_q, pii_q, pri_q;
	logic signed [VW-1:0] zrr_q, zii_q, zri_q, zir_q;
	logic signed [VW-1:0] ddr_q, ddi_q;
	logic signed [VW-1:0] nrd_q, nid_q, nir_q, nri_q;
	logic [PW-1:0]        ex2_q, ey2_q;
	logic [15:0]          it_q;
	logic                 conv_q;

	logic                 mul_start, mul_done, mul_neg;
	logic signed [VW-1:0] mul_a, mul_b;
	logic [PW-1:0]        mul_prod;
	logic                 div_start, div_done;
	logic signed [VW-1:0] div_p, div_q;

	logic [PW-FB-1:0]     fx_m;
	logic signed [VW-1:0] fx_mag, fx_res;
	logic signed [VW-1:0] z2r, z2i, dr, di, z3r, z3i, nr, ni, n2, dn, pr, pim;
	logic signed [ZW-1:0] ex, ey, azr, azi;
	logic                 esc, n2_bad, dn_bad, near;
	logic [MV_W-1:0]      mv;
	logic [7:0]           pal;

	assign fx_m   = mul_prod[PW-1:FB];
	assign fx_mag = $signed(VW'(fx_m)) + $signed(VW'(mul_neg && (|mul_prod[FB-1:0])));
	assign fx_res = mul_neg ? -fx_mag : fx_mag;

	assign z2r = prr_q - pii_q;
	assign z2i = pri_q <<< 1;
	assign dr  = z2r + (z2r <<< 1);
	assign di  = z2i + (z2i <<< 1);
	assign z3r = zrr_q - zii_q;
	assign z3i = zri_q + zir_q;
	assign nr  = z3r - nfp_pkg::FX_ONE_V;
	assign ni  = z3i;
	assign n2  = prr_q + pii_q;
	assign dn  = ddr_q + ddi_q;
	assign pr  = nrd_q + nid_q;
	assign pim = nir_q - nri_q;

	assign azr    = zr_q[ZW-1] ? -zr_q : zr_q;
	assign azi    = zi_q[ZW-1] ? -zi_q : zi_q;
	assign esc    = (azr > nfp_pkg::ESC_LIMIT) || (azi > nfp_pkg::ESC_LIMIT);
	assign n2_bad = (n2 > nfp_pkg::N2_LIMIT) || (n2 == '0);
	assign dn_bad = (dn == '0);
	assign near   = ({1'b0, ex2_q} + {1'b0, ey2_q}) < nfp_pkg::THR;

	assign mv  = MV_W'(root_q) * MV_W'(5) + MV_W'(it_q);
	assign pal = 8'(mv % MV_W'(nfp_pkg::PALETTE_LENGTH));

	always_comb begin
		ex = zr_q - nfp_pkg::FX_ONE_Z;
		ey = zi_q;
		unique case (root_d)
			2'd1: begin
				ex = zr_q + nfp_pkg::FX_HALF_Z;
				ey = zi_q - nfp_pkg::HALF_ROOT;
			end
			2'd2: begin
				ex = zr_q + nfp_pkg::FX_HALF_Z;
				ey = zi_q + nfp_pkg::HALF_ROOT;
			end
			default: begin
				ex = zr_q - nfp_pkg::FX_ONE_Z;
				ey = zi_q;
			end
		endcase
	end

	always_comb begin
		mul_a = zr_q[VW-1:0];
		mul_b = zr_q[VW-1:0];
		unique case (mop_d)
			nfp_pkg::M_RR:  begin mul_a = zr_q[VW-1:0]; mul_b = zr_q[VW-1:0]; end
			nfp_pkg::M_II:  begin mul_a = zi_q[VW-1:0]; mul_b = zi_q[VW-1:0]; end
			nfp_pkg::M_RI:  begin mul_a = zr_q[VW-1:0]; mul_b = zi_q[VW-1:0]; end
			nfp_pkg::M_ZRR: begin mul_a = z2r; mul_b = zr_q[VW-1:0]; end
			nfp_pkg::M_ZII: begin mul_a = z2i; mul_b = zi_q[VW-1:0]; end
			nfp_pkg::M_ZRI: begin mul_a = z2r; mul_b = zi_q[VW-1:0]; end
			nfp_pkg::M_ZIR: begin mul_a = z2i; mul_b = zr_q[VW-1:0]; end
			nfp_pkg::M_DRR: begin mul_a = dr; mul_b = dr; end
			nfp_pkg::M_DII: begin mul_a = di; mul_b = di; end
			nfp_pkg::M_NRD: begin mul_a = nr; mul_b = dr; end
			nfp_pkg::M_NID: begin mul_a = ni; mul_b = di; end
			nfp_pkg::M_NIR: begin mul_a = ni; mul_b = dr; end
			nfp_pkg::M_NRI: begin mul_a = nr; mul_b = di; end
			nfp_pkg::M_EX:  begin mul_a = ex[VW-1:0]; mul_b = ex[VW-1:0]; end
			nfp_pkg::M_EY:  begin mul_a = ey[VW-1:0]; mul_b = ey[VW-1:0]; end
			default:        begin mul_a = zr_q[VW-1:0]; mul_b = zr_q[VW-1:0]; end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		mop_d     = mop_q;
		root_d    = root_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		div_p     = pr;
		pop       = 1'b0;
		unique case (state_q)
			nfp_pkg::S_IDLE: begin
				if (pt_valid) begin
					pop     = 1'b1;
					state_d = nfp_pkg::S_CHECK;
				end
			end
			nfp_pkg::S_CHECK: begin
				if (it_q >= limit || esc) begin
					state_d = nfp_pkg::S_OUT;
				end else begin
					mop_d     = nfp_pkg::M_RR;
					mul_start = 1'b1;
					state_d   = nfp_pkg::S_MUL;
				end
			end
			nfp_pkg::S_MUL: begin
				if (mul_done) begin
					unique case (mop_q)
						nfp_pkg::M_RI:  state_d = nfp_pkg::S_NORM;
						nfp_pkg::M_DII: state_d = nfp_pkg::S_DEN;
						nfp_pkg::M_EY:  state_d = nfp_pkg::S_ROOT;
						nfp_pkg::M_NRI: begin
							div_start = 1'b1;
							div_p     = pr;
							state_d   = nfp_pkg::S_DIVR;
						end
						nfp_pkg::M_RR:  begin mop_d = nfp_pkg::M_II;  mul_start = 1'b1; end
						nfp_pkg::M_II:  begin mop_d = nfp_pkg::M_RI;  mul_start = 1'b1; end
						nfp_pkg::M_ZRR: begin mop_d = nfp_pkg::M_ZII; mul_start = 1'b1; end
						nfp_pkg::M_ZII: begin mop_d = nfp_pkg::M_ZRI; mul_start = 1'b1; end
						nfp_pkg::M_ZRI: begin mop_d = nfp_pkg::M_ZIR; mul_start = 1'b1; end
						nfp_pkg::M_ZIR: begin mop_d = nfp_pkg::M_DRR; mul_start = 1'b1; end
						nfp_pkg::M_DRR: begin mop_d = nfp_pkg::M_DII; mul_start = 1'b1; end
						nfp_pkg::M_NRD: begin mop_d = nfp_pkg::M_NID; mul_start = 1'b1; end
						nfp_pkg::M_NID: begin mop_d = nfp_pkg::M_NIR; mul_start = 1'b1; end
						nfp_pkg::M_NIR: begin mop_d = nfp_pkg::M_NRI; mul_start = 1'b1; end
						nfp_pkg::M_EX:  begin mop_d = nfp_pkg::M_EY;  mul_start = 1'b1; end
						default:        state_d = nfp_pkg::S_OUT;
					endcase
				end
			end
			nfp_pkg::S_NORM: begin
				if (n2_bad) begin
					state_d = nfp_pkg::S_OUT;
				end else begin
					mop_d     = nfp_pkg::M_ZRR;
					mul_start = 1'b1;
					state_d   = nfp_pkg::S_MUL;
				end
			end
			nfp_pkg::S_DEN: begin
				root_d = 2'd0;
				if (dn_bad) begin
					state_d = nfp_pkg::S_OUT;
				end else begin
					mop_d     = nfp_pkg::M_NRD;
					mul_start = 1'b1;
					state_d   = nfp_pkg::S_MUL;
				end
			end
			nfp_pkg::S_DIVR: begin
				if (div_done) begin
					div_start = 1'b1;
					div_p     = pim;
					state_d   = nfp_pkg::S_DIVI;
				end
			end
			nfp_pkg::S_DIVI: begin
				if (div_done) begin
					mop_d     = nfp_pkg::M_EX;
					mul_start = 1'b1;
					state_d   = nfp_pkg::S_MUL;
				end
			end
			nfp_pkg::S_ROOT: begin
				if (near) begin
					state_d = nfp_pkg::S_OUT;
				end else if (root_q == 2'd2) begin
					state_d = nfp_pkg::S_CHECK;
				end else begin
					root_d    = root_q + 2'd1;
					mop_d     = nfp_pkg::M_EX;
					mul_start = 1'b1;
					state_d   = nfp_pkg::S_MUL;
				end
			end
			nfp_pkg::S_OUT: begin
				if (!out_valid) begin
					state_d = nfp_pkg::S_IDLE;
				end
			end
			default: state_d = nfp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nfp_pkg::S_IDLE;
			mop_q     <= nfp_pkg::M_RR;
			root_q    <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			mop_q   <= mop_d;
			root_q  <= root_d;
			if (state_q == nfp_pkg::S_OUT && !out_valid) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			nfp_pkg::S_IDLE: begin
				if (pt_valid) begin
					zr_q   <= pt.zr;
					zi_q   <= pt.zi;
					it_q   <= '0;
					conv_q <= 1'b0;
				end
			end
			nfp_pkg::S_MUL: begin
				if (mul_done) begin
					unique case (mop_q)
						nfp_pkg::M_RR:  prr_q <= fx_res;
						nfp_pkg::M_II:  pii_q <= fx_res;
						nfp_pkg::M_RI:  pri_q <= fx_res;
						nfp_pkg::M_ZRR: zrr_q <= fx_res;
						nfp_pkg::M_ZII: zii_q <= fx_res;
						nfp_pkg::M_ZRI: zri_q <= fx_res;
						nfp_pkg::M_ZIR: zir_q <= fx_res;
						nfp_pkg::M_DRR: ddr_q <= fx_res;
						nfp_pkg::M_DII: ddi_q <= fx_res;
						nfp_pkg::M_NRD: nrd_q <= fx_res;
						nfp_pkg::M_NID: nid_q <= fx_res;
						nfp_pkg::M_NIR: nir_q <= fx_res;
						nfp_pkg::M_NRI: nri_q <= fx_res;
						nfp_pkg::M_EX:  ex2_q <= mul_prod;
						nfp_pkg::M_EY:  ey2_q <= mul_prod;
						default:        prr_q <= fx_res;
					endcase
				end
			end
			nfp_pkg::S_DIVR: begin
				if (div_done) begin
					zr_q <= zr_q - ZW'(div_q);
				end
			end
			nfp_pkg::S_DIVI: begin
				if (div_done) begin
					zi_q <= zi_q - ZW'(div_q);
					it_q <= it_q + 16'd1;
				end
			end
			nfp_pkg::S_ROOT: begin
				if (near) begin
					conv_q <= 1'b1;
				end
			end
			nfp_pkg::S_OUT: begin
				if (!out_valid) begin
					result.converged     <= conv_q;
					result.root_index    <= conv_q ? root_q : 2'd0;
					result.step_count    <= it_q;
					result.palette_index <= conv_q ? pal : 8'd0;
				end
			end
			default: begin
			end
		endcase
	end

	nfp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod),
		.neg    (mul_neg)
	);

	nfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.p      (div_p),
		.d      (dn),
		.done   (div_done),
		.quot   (div_q)
	);

endmodule
